/* rtl/wsg_pkg.sv */
// Shared constants, types and the exp2 coefficient table of the windowed gain unit.
package wsg_pkg;

   localparam int WinMax    = 1024;
   localparam int PtrW      = $clog2(WinMax);
   localparam int WinW      = PtrW + 1;
   localparam int FracW     = 30;
   localparam int SumW      = 44;
   localparam int OpaW      = 64;
   localparam int OpbW      = SumW;
   localparam int DivSteps  = OpaW;
   localparam int SqrtSteps = OpaW / 2;
   localparam int CntW      = $clog2(DivSteps);

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   typedef logic [31:0] coef_tab_type [FracW];

   function automatic logic [63:0] isqrt_const(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = val;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // entry j holds the factor for fraction bit j, i.e. 2^(2^(j-30))
   function automatic coef_tab_type exp_coef_tab();
      coef_tab_type tab;
      logic [63:0]  c;
      c = 64'h8000_0000;
      for (int i = 1; i <= FracW; i++) begin
         c = isqrt_const(c << FracW);
         tab[FracW - i] = c[31:0];
      end
      return tab;
   endfunction

   localparam coef_tab_type ExpCoef = exp_coef_tab();

endpackage

/* rtl/windowed_shannon_gain_unit.sv */
// Windowed Shannon probability and gain of a price series, iterative datapath.
//
// Requests enter on req_ (tdata: sample_value, sample_time; tuser: has_time), one
// at a time; req_tready is high only while the sequencer is idle. Results leave on
// rsp_ (tdata: time_out, gain; tuser: status) through an output register, so the
// next request is taken while a result still waits for rsp_tready.
// The window length is written on the csr_ port, which is always ready.
// After reset the ring memory is cleared, one entry per cycle, with req_tready low
// until all 1024 entries are clear. The first sample only sets the previous value
// and gives no result. A later sample that gives no result runs the return
// division (64 steps), or skips it when the previous sample was zero. A sample that
// gives a result with status ok runs four 64-step divisions and one 32-step square
// root in the shared divider/root unit, two 30-bit log2 loops and one 30-bit exp2
// loop on the shared 32x32 multiplier, plus shifts to normalize 1-rms. A nonzero
// status skips the root, logs and exp, and also the return division when the
// previous sample was zero.
// If rsp_tready is low when a second result is ready, the sequencer holds until
// the output register empties; nothing is dropped.
module windowed_shannon_gain_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // sample_value[31:0], sample_time[63:32]
   input  logic [0:0]                req_tuser,   // has_time[0]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [63:0]               rsp_tdata,   // time_out[31:0], gain[63:32]
   output logic [1:0]                rsp_tuser,   // status[1:0]
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [wsg_pkg::WinW-1:0]  csr_wdata
);

   localparam int PtrW  = wsg_pkg::PtrW;
   localparam int WinW  = wsg_pkg::WinW;
   localparam int SumW  = wsg_pkg::SumW;
   localparam int OpaW  = wsg_pkg::OpaW;
   localparam int OpbW  = wsg_pkg::OpbW;
   localparam int Depth = wsg_pkg::WinMax;

   localparam logic [30:0]     One31    = 31'h4000_0000;
   localparam logic [OpaW-1:0] OneW     = OpaW'(32'h4000_0000);
   localparam logic [OpaW-1:0] AvgMaxW  = OpaW'(32'h8000_0000);
   localparam logic [WinW-1:0] WinReset = WinW'(10);
   localparam logic [WinW-1:0] WinTop   = WinW'(Depth);
   localparam logic [4:0]      BitTop   = 5'd29;

   localparam logic [1:0] StatOk       = 2'd0;
   localparam logic [1:0] StatPrevZero = 2'd1;
   localparam logic [1:0] StatRmsZero  = 2'd2;
   localparam logic [1:0] StatRmsBig   = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RET_WAIT, ST_CHECK, ST_MS_WAIT, ST_RMS_WAIT, ST_AVG_WAIT,
      ST_RATIO_WAIT, ST_LOG_NORM, ST_LOG_MUL, ST_LOG_SQ, ST_T1_MUL, ST_T2A_MUL,
      ST_T2B_MUL, ST_EXPO, ST_EXP_MUL, ST_EXP_ACC, ST_EXP_SHIFT, ST_EMIT, ST_SQ_MUL,
      ST_UPDATE
   } state_type;

   state_type              state_ff;
   logic [PtrW-1:0]        clr_ff;
   logic [WinW-1:0]        win_ff;
   logic [WinW-1:0]        weff_ff;
   logic [31:0]            cur_ff;
   logic [31:0]            tout_ff;
   logic [31:0]            prev_ff;
   logic [31:0]            count_ff;
   logic [PtrW-1:0]        ptr_ff;
   logic signed [SumW-1:0] rsum_ff;
   logic [SumW-1:0]        ssum_ff;
   logic                   neg_ff;
   logic signed [31:0]     r_ff;
   logic [63:0]            rd_ff;
   logic [29:0]            rms_ff;
   logic                   aneg_ff;
   logic [30:0]            p_ff;
   logic [30:0]            m_ff;
   logic [4:0]             kn_ff;
   logic [29:0]            f_ff;
   logic [4:0]             bit_ff;
   logic                   lsel_ff;
   logic [29:0]            l1_ff;
   logic [34:0]            m2_ff;
   logic [30:0]            t1_ff;
   logic [35:0]            t2_ff;
   logic signed [36:0]     e_ff;
   logic [30:0]            v_ff;
   logic [31:0]            gain_ff;
   logic [1:0]             stat_ff;
   logic                   rsp_valid_ff;
   logic [63:0]            rsp_data_ff;
   logic [1:0]             rsp_stat_ff;
   logic [63:0]            prod_ff;
   wsg_pkg::arith_cmd_type cmd_ff;
   logic [OpaW-1:0]        opa_ff;
   logic [OpbW-1:0]        opb_ff;

   logic [63:0]            ring_mem [Depth];

   wsg_pkg::arith_stat_type ar_stat;
   logic [OpaW-1:0]        ar_res;

   logic                   acc;
   logic [31:0]            in_cur;
   logic [WinW-1:0]        weff_c;
   logic [PtrW-1:0]        pe;
   logic [31:0]            dmag;
   logic signed [31:0]     r_sat;
   logic [31:0]            rmag;
   logic [31:0]            sq_c;
   logic signed [31:0]     old_r;
   logic [SumW-1:0]        rsum_mag;
   logic [31:0]            am;
   logic [30:0]            ratio;
   logic [31:0]            psum;
   logic [30:0]            qp;
   logic [31:0]            sqr_s;
   logic [29:0]            f_new;
   logic [35:0]            t2_sum;
   logic [29:0]            e_frac;
   logic [31:0]            gain_c;
   logic [PtrW:0]          ptr_inc;
   logic [31:0]            mul_a;
   logic [31:0]            mul_b;
   logic [63:0]            mul_p;
   logic                   mem_we;
   logic [PtrW-1:0]        mem_addr;
   logic [63:0]            mem_wdata;

   wsg_arith_unit u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .stat   (ar_stat),
      .result (ar_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign acc        = req_tvalid && req_tready;
   assign in_cur     = req_tdata[31:0];

   assign weff_c = (win_ff == '0) ? WinW'(1) : ((win_ff > WinTop) ? WinTop : win_ff);
   assign pe     = ({1'b0, ptr_ff} >= weff_c) ? '0 : ptr_ff;
   assign dmag   = (in_cur >= prev_ff) ? (in_cur - prev_ff) : (prev_ff - in_cur);

   always_comb begin
      if (neg_ff) begin
         r_sat = (|ar_res[63:31]) ? 32'sh8000_0000 : -$signed(ar_res[31:0]);
      end else begin
         r_sat = (|ar_res[63:31]) ? 32'sh7FFF_FFFF : $signed(ar_res[31:0]);
      end
   end

   assign rmag     = r_ff[31] ? 32'(-r_ff) : 32'(r_ff);
   assign sq_c     = (|prod_ff[63:62]) ? 32'hFFFF_FFFF : prod_ff[61:30];
   assign old_r    = $signed(rd_ff[63:32]);
   assign rsum_mag = rsum_ff[SumW-1] ? SumW'(-rsum_ff) : SumW'(rsum_ff);
   assign am       = (ar_res > AvgMaxW) ? 32'h8000_0000 : ar_res[31:0];
   assign ratio    = (ar_res > OneW) ? One31 : ar_res[30:0];
   assign psum     = aneg_ff ? ({1'b0, One31} - {1'b0, ratio}) : ({1'b0, One31} + {1'b0, ratio});
   assign qp       = One31 - p_ff;
   assign sqr_s    = prod_ff[61:30];
   assign f_new    = f_ff | (sqr_s[31] ? (30'd1 << bit_ff) : 30'd0);
   assign t2_sum   = t2_ff + 36'(prod_ff[59:30]);
   assign e_frac   = e_ff[29:0];
   assign ptr_inc  = {1'b0, ptr_ff} + 1'b1;

   always_comb begin
      logic signed [6:0] n;
      logic [6:0]        nm;
      n  = e_ff[36:30];
      nm = 7'(-n);
      if (!n[6]) begin
         if (n >= 7'sd2) begin
            gain_c = 32'hFFFF_FFFF;
         end else if (n == 7'sd1) begin
            gain_c = {v_ff, 1'b0};
         end else begin
            gain_c = {1'b0, v_ff};
         end
      end else if (nm >= 7'd32) begin
         gain_c = '0;
      end else begin
         gain_c = {1'b0, v_ff} >> nm[4:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_LOG_MUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         ST_T1_MUL: begin
            mul_a = {1'b0, p_ff};
            mul_b = {2'b0, l1_ff};
         end
         ST_T2A_MUL: begin
            mul_a = {1'b0, qp};
            mul_b = {27'b0, m2_ff[34:30]};
         end
         ST_T2B_MUL: begin
            mul_a = {1'b0, qp};
            mul_b = {2'b0, m2_ff[29:0]};
         end
         ST_EXP_MUL: begin
            mul_a = {1'b0, v_ff};
            mul_b = e_frac[bit_ff] ? wsg_pkg::ExpCoef[bit_ff] : {1'b0, One31};
         end
         ST_SQ_MUL: begin
            mul_a = rmag;
            mul_b = rmag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
   end

   assign mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
   assign mem_addr  = (state_ff == ST_CLEAR) ? clr_ff : ptr_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? 64'd0 : {r_ff, sq_c};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= mem_wdata;
      end
      if (acc) begin
         rd_ff <= ring_mem[pe];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         win_ff       <= WinReset;
         count_ff     <= '0;
         ptr_ff       <= '0;
         prev_ff      <= '0;
         rsum_ff      <= '0;
         ssum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
      end else begin
         if (csr_valid) begin
            win_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (acc) begin
                  cur_ff  <= in_cur;
                  tout_ff <= req_tuser[0] ? req_tdata[63:32] : count_ff;
                  weff_ff <= weff_c;
                  if (count_ff == '0) begin
                     prev_ff  <= in_cur;
                     count_ff <= 32'd1;
                  end else if (prev_ff == '0) begin
                     ptr_ff   <= pe;
                     r_ff     <= (in_cur != '0) ? 32'sh7FFF_FFFF : 32'sh0;
                     state_ff <= ST_CHECK;
                  end else begin
                     ptr_ff   <= pe;
                     neg_ff   <= in_cur < prev_ff;
                     opa_ff   <= {2'b0, dmag, 30'b0};
                     opb_ff   <= OpbW'(prev_ff);
                     cmd_ff   <= '{start: 1'b1, op: wsg_pkg::OP_DIV};
                     state_ff <= ST_RET_WAIT;
                  end
               end
            end
            ST_RET_WAIT: begin
               if (ar_stat.done) begin
                  r_ff     <= r_sat;
                  state_ff <= ST_CHECK;
               end else begin
                  cmd_ff.start <= 1'b0;
               end
            end
            ST_CHECK: begin
               if (count_ff >= 32'(weff_ff)) begin
                  opa_ff   <= OpaW'(ssum_ff);
                  opb_ff   <= OpbW'(weff_ff);
                  cmd_ff   <= '{start: 1'b1, op: wsg_pkg::OP_DIV};
                  state_ff <= ST_MS_WAIT;
               end else begin
                  state_ff <= ST_SQ_MUL;
               end
            end
            ST_MS_WAIT: begin
               if (ar_stat.done) begin
                  gain_ff <= '0;
                  if (prev_ff == '0) begin
                     stat_ff  <= StatPrevZero;
                     state_ff <= ST_EMIT;
                  end else if (ar_res == '0) begin
                     stat_ff  <= StatRmsZero;
                     state_ff <= ST_EMIT;
                  end else if (ar_res >= OneW) begin
                     stat_ff  <= StatRmsBig;
                     state_ff <= ST_EMIT;
                  end else begin
                     stat_ff  <= StatOk;
                     opa_ff   <= {4'b0, ar_res[29:0], 30'b0};
                     cmd_ff   <= '{start: 1'b1, op: wsg_pkg::OP_SQRT};
                     state_ff <= ST_RMS_WAIT;
                  end
               end else begin
                  cmd_ff.start <= 1'b0;
               end
            end
            ST_RMS_WAIT: begin
               if (ar_stat.done) begin
                  rms_ff   <= ar_res[29:0];
                  aneg_ff  <= rsum_ff[SumW-1];
                  opa_ff   <= OpaW'(rsum_mag);
                  opb_ff   <= OpbW'(weff_ff);
                  cmd_ff   <= '{start: 1'b1, op: wsg_pkg::OP_DIV};
                  state_ff <= ST_AVG_WAIT;
               end else begin
                  cmd_ff.start <= 1'b0;
               end
            end
            ST_AVG_WAIT: begin
               if (ar_stat.done) begin
                  opa_ff   <= {2'b0, am, 30'b0};
                  opb_ff   <= OpbW'(rms_ff);
                  cmd_ff   <= '{start: 1'b1, op: wsg_pkg::OP_DIV};
                  state_ff <= ST_RATIO_WAIT;
               end else begin
                  cmd_ff.start <= 1'b0;
               end
            end
            ST_RATIO_WAIT: begin
               if (ar_stat.done) begin
                  p_ff     <= psum[31:1];
                  m_ff     <= One31 + 31'(rms_ff);
                  kn_ff    <= '0;
                  f_ff     <= '0;
                  bit_ff   <= BitTop;
                  lsel_ff  <= 1'b0;
                  state_ff <= ST_LOG_MUL;
               end else begin
                  cmd_ff.start <= 1'b0;
               end
            end
            ST_LOG_NORM: begin
               if (!m_ff[30]) begin
                  m_ff  <= {m_ff[29:0], 1'b0};
                  kn_ff <= kn_ff + 1'b1;
               end else begin
                  state_ff <= ST_LOG_MUL;
               end
            end
            ST_LOG_MUL: begin
               state_ff <= ST_LOG_SQ;
            end
            ST_LOG_SQ: begin
               if (bit_ff != '0) begin
                  m_ff     <= sqr_s[31] ? sqr_s[31:1] : sqr_s[30:0];
                  f_ff     <= f_new;
                  bit_ff   <= bit_ff - 1'b1;
                  state_ff <= ST_LOG_MUL;
               end else if (!lsel_ff) begin
                  l1_ff    <= f_new;
                  m_ff     <= One31 - 31'(rms_ff);
                  kn_ff    <= '0;
                  f_ff     <= '0;
                  bit_ff   <= BitTop;
                  lsel_ff  <= 1'b1;
                  state_ff <= ST_LOG_NORM;
               end else begin
                  m2_ff    <= {kn_ff, 30'b0} - 35'(f_new);
                  state_ff <= ST_T1_MUL;
               end
            end
            ST_T1_MUL: begin
               state_ff <= ST_T2A_MUL;
            end
            ST_T2A_MUL: begin
               t1_ff    <= prod_ff[60:30];
               state_ff <= ST_T2B_MUL;
            end
            ST_T2B_MUL: begin
               t2_ff    <= prod_ff[35:0];
               state_ff <= ST_EXPO;
            end
            ST_EXPO: begin
               e_ff     <= $signed({6'b0, t1_ff}) - $signed({1'b0, t2_sum});
               v_ff     <= One31;
               bit_ff   <= BitTop;
               state_ff <= ST_EXP_MUL;
            end
            ST_EXP_MUL: begin
               state_ff <= ST_EXP_ACC;
            end
            ST_EXP_ACC: begin
               v_ff <= prod_ff[60:30];
               if (bit_ff == '0) begin
                  state_ff <= ST_EXP_SHIFT;
               end else begin
                  bit_ff   <= bit_ff - 1'b1;
                  state_ff <= ST_EXP_MUL;
               end
            end
            ST_EXP_SHIFT: begin
               gain_ff  <= gain_c;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {gain_ff, tout_ff};
                  rsp_stat_ff  <= stat_ff;
                  state_ff     <= ST_SQ_MUL;
               end
            end
            ST_SQ_MUL: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               rsum_ff  <= rsum_ff - SumW'(old_r) + SumW'(r_ff);
               ssum_ff  <= ssum_ff - SumW'(rd_ff[31:0]) + SumW'(sq_c);
               ptr_ff   <= (ptr_inc >= weff_ff) ? '0 : ptr_inc[PtrW-1:0];
               prev_ff  <= cur_ff;
               if (count_ff != '1) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

`ifndef ASSERT_OFF
   a_gain_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != StatOk) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("nonzero gain with error status");
   a_wait_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RET_WAIT || state_ff == ST_MS_WAIT || state_ff == ST_RMS_WAIT ||
       state_ff == ST_AVG_WAIT || state_ff == ST_RATIO_WAIT)
      |-> (ar_stat.busy || ar_stat.done || cmd_ff.start))
      else $error("sequencer waits on an idle arith unit");
   a_ptr_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> ({1'b0, ptr_ff} < weff_ff))
      else $error("ring pointer left the window");
   a_rms_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RATIO_WAIT) |-> (rms_ff != '0))
      else $error("ratio division by zero rms");
`endif

endmodule

/* rtl/wsg_arith_unit.sv */
// Shared bit-serial divider and square root unit, one result bit per cycle.
module wsg_arith_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  wsg_pkg::arith_cmd_type      cmd,
   input  logic [wsg_pkg::OpaW-1:0]    opa,
   input  logic [wsg_pkg::OpbW-1:0]    opb,
   output wsg_pkg::arith_stat_type     stat,
   output logic [wsg_pkg::OpaW-1:0]    result
);

   localparam int OpaW = wsg_pkg::OpaW;
   localparam int OpbW = wsg_pkg::OpbW;
   localparam int CntW = wsg_pkg::CntW;
   localparam logic [CntW-1:0] DivLast  = CntW'(wsg_pkg::DivSteps - 1);
   localparam logic [CntW-1:0] SqrtLast = CntW'(wsg_pkg::SqrtSteps - 1);
   localparam logic [OpaW-1:0] SqrtBit0 = OpaW'(1) << (OpaW - 2);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CntW-1:0]       cnt_ff;
   wsg_pkg::arith_op_type op_ff;
   logic [OpbW-1:0]       dsor_ff;
   logic [OpbW:0]         rem_ff;
   logic [OpaW-1:0]       quo_ff;
   logic [OpaW-1:0]       sqv_ff;
   logic [OpaW-1:0]       sqr_ff;
   logic [OpaW-1:0]       sqb_ff;

   logic [OpbW:0]         rem_sh;
   logic                  div_ge;
   logic [OpaW-1:0]       sq_sum;
   logic                  sq_ge;
   logic [CntW-1:0]       last_cnt;

   assign rem_sh   = {rem_ff[OpbW-1:0], quo_ff[OpaW-1]};
   assign div_ge   = rem_sh >= {1'b0, dsor_ff};
   assign sq_sum   = sqr_ff + sqb_ff;
   assign sq_ge    = sqv_ff >= sq_sum;
   assign last_cnt = (op_ff == wsg_pkg::OP_DIV) ? DivLast : SqrtLast;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            op_ff   <= cmd.op;
            quo_ff  <= opa;
            rem_ff  <= '0;
            dsor_ff <= opb;
            sqv_ff  <= opa;
            sqr_ff  <= '0;
            sqb_ff  <= SqrtBit0;
         end else if (busy_ff) begin
            if (op_ff == wsg_pkg::OP_DIV) begin
               rem_ff <= div_ge ? (rem_sh - {1'b0, dsor_ff}) : rem_sh;
               quo_ff <= {quo_ff[OpaW-2:0], div_ge};
            end else begin
               if (sq_ge) begin
                  sqv_ff <= sqv_ff - sq_sum;
                  sqr_ff <= (sqr_ff >> 1) + sqb_ff;
               end else begin
                  sqr_ff <= sqr_ff >> 1;
               end
               sqb_ff <= sqb_ff >> 2;
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == last_cnt) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = (op_ff == wsg_pkg::OP_DIV) ? quo_ff : sqr_ff;

`ifndef ASSERT_OFF
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("arith unit started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("arith done held longer than one cycle");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("arith done while still busy");
   a_sqrt_len: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && op_ff == wsg_pkg::OP_SQRT) |-> (cnt_ff <= SqrtLast))
      else $error("square root ran past its step count");
`endif

endmodule
